[design/sef_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sef_pkg
// Shared types and constants of the selectable EMA, low-pass and median filter.
// ----------------------------------------------------------------------------
package sef_pkg;

    localparam int CNT_W      = 5;
    localparam int GAIN_BITS  = 24;
    localparam int FRAC_EXTRA = 8;
    localparam int DT_W       = 20;
    localparam int P_W        = 40;
    localparam int W_W        = 60;
    localparam int DEN_W      = 61;
    localparam int C_W        = 19;

    localparam logic [C_W-1:0]   TWO_PI_Q16   = 19'd411775;
    localparam logic [DEN_W-1:0] UNIT_SCALED  = 61'd65536000000000;
    localparam logic [DT_W-1:0]  DEFAULT_STEP = 20'd20000;
    localparam logic [DT_W-1:0]  MAX_STEP     = 20'd1000000;
    localparam logic [19:0]      MIN_CUTOFF   = 20'd100;
    localparam logic [16:0]      ALPHA_ONE    = 17'd65536;

    localparam logic [1:0] MODE_EMA = 2'd0;
    localparam logic [1:0] MODE_LP  = 2'd1;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_DINIT = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_UPD   = 8'b0010_0000,
        ST_SORT  = 8'b0100_0000,
        ST_PICK  = 8'b1000_0000
    } sef_state_t;

    typedef struct packed {
        logic load;
        logic sort_load;
        logic mul0;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic update;
        logic sort_step;
        logic phase;
        logic shift;
        logic emit;
    } sef_cmd_t;

    typedef struct packed {
        logic             mode_med;
        logic             mode_lp;
        logic [CNT_W-1:0] half;
    } sef_sts_t;

endpackage : sef_pkg
`default_nettype wire

[design/selectable_ema_lowpass_median_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// selectable_ema_lowpass_median_filter
// Exponential average, RC low-pass or sliding median over a sample stream.
// ----------------------------------------------------------------------------
// Work per item: EMA a single update; low-pass one 20x20 multiply, two partial
// products and 24 divider steps; median WINDOW_DEPTH sorter passes plus up to
// (WINDOW_DEPTH-1)/2 shifts.
// One item is in work at a time; the next input beat is taken while the output
// register still holds the previous result.
// Reset is synchronous, active low; any configuration write clears the filter states and the sample window.
module selectable_ema_lowpass_median_filter import sef_pkg::*; #(
    parameter int WINDOW_DEPTH = 21,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // sample_in, step_micros, zero fill
    input  wire logic [((SAMPLE_BITS+27)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // filtered_out, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [1:0]                       cfg_addr,
    input  wire logic [19:0]                      cfg_wdata
);

    localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;

    sef_cmd_t cmd;
    sef_sts_t sts;

    logic [1:0]  mode_reg;
    logic [16:0] weight_reg;
    logic [4:0]  window_reg;
    logic [19:0] cutoff_reg;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_data_reg;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OW'($unsigned(m_data_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_EMA;
            weight_reg <= 17'd6554;
            window_reg <= 5'd5;
            cutoff_reg <= 20'd1000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODE:   mode_reg   <= cfg_wdata[1:0];
                REG_WEIGHT: weight_reg <= cfg_wdata[16:0];
                REG_WINDOW: window_reg <= cfg_wdata[4:0];
                REG_CUTOFF: cutoff_reg <= cfg_wdata;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= y;
        end
    end

    sef_ctrl #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .out_free(out_free),
        .sts     (sts),
        .cmd     (cmd)
    );

    sef_datapath #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_clear        (cfg_wr_en),
        .filter_mode      (mode_reg),
        .ema_weight       (weight_reg),
        .median_window    (window_reg),
        .cutoff_millihertz(cutoff_reg),
        .sample_in        ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .step_micros      (s_tdata[SAMPLE_BITS+DT_W-1:SAMPLE_BITS]),
        .filtered_out     (y)
    );

endmodule : selectable_ema_lowpass_median_filter
`default_nettype wire

[design/sef_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sef_ctrl
// Sequencer: steps the datapath through one item and hands off the result.
// ----------------------------------------------------------------------------
module sef_ctrl import sef_pkg::*; #(
    parameter int WINDOW_DEPTH = 21
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     out_free,
    input  wire sef_sts_t sts,
    output sef_cmd_t      cmd
);

    localparam logic [CNT_W-1:0] SORT_LAST = CNT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(GAIN_BITS - 1);

    sef_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    assign in_ready = (state_reg == ST_IDLE) && !done_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.phase  = cnt_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (done_reg) begin
                    if (out_free) begin
                        cmd.emit  = 1'b1;
                        done_next = 1'b0;
                    end
                end else if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cnt_next = '0;
                if (sts.mode_med) begin
                    cmd.sort_load = 1'b1;
                    state_next    = ST_SORT;
                end else if (sts.mode_lp) begin
                    cmd.mul0   = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_MUL: begin
                if (cnt_reg == '0) begin
                    cmd.mul_lo = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end else begin
                    cmd.mul_hi = 1'b1;
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SORT: begin
                cmd.sort_step = 1'b1;
                if (cnt_reg == SORT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_PICK;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PICK: begin
                if (cnt_reg == sts.half) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    a_accept_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start the sequence");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider ran past its last step");
    a_pick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |-> (cnt_reg <= sts.half))
        else $error("median pick ran past the middle");

endmodule : sef_ctrl
`default_nettype wire

[design/sef_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sef_datapath
// Filter states, window store, gain divider, sorter and output rounding.
// ----------------------------------------------------------------------------
module sef_datapath import sef_pkg::*; #(
    parameter int WINDOW_DEPTH = 21,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sef_cmd_t                      cmd,
    output sef_sts_t                           sts,
    input  wire logic                          cfg_clear,
    input  wire logic [1:0]                    filter_mode,
    input  wire logic [16:0]                   ema_weight,
    input  wire logic [4:0]                    median_window,
    input  wire logic [19:0]                   cutoff_millihertz,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic [DT_W-1:0]               step_micros,
    output logic signed [SAMPLE_BITS-1:0]      filtered_out
);

    localparam int S  = SAMPLE_BITS;
    localparam int D  = WINDOW_DEPTH;
    localparam int SW = S + FRAC_EXTRA;
    localparam logic [CNT_W-1:0] D_CNT = CNT_W'(D);
    localparam logic signed [SW:0] Y_HI = (SW+1)'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [SW:0] Y_LO = -Y_HI - (SW+1)'(1);

    logic signed [S-1:0]     x_reg;
    logic [DT_W-1:0]         dt_reg;
    logic [P_W-1:0]          p_reg;
    logic [W_W-1:0]          w_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [GAIN_BITS-1:0]    q_reg;
    logic                    seeded_reg;
    logic signed [SW-1:0]    avg_reg;
    logic signed [SW-1:0]    lp_reg;
    logic [CNT_W-1:0]        held_reg;
    logic [CNT_W-1:0]        wlen_reg;
    logic signed [S-1:0]     win_reg [D];
    logic signed [S-1:0]     srt_reg [D];
    logic                    inv_reg [D];

    logic [DT_W-1:0]         dt_fix;
    logic [19:0]             fc_fix;
    logic [16:0]             alpha;
    logic [CNT_W-1:0]        wlen_calc;
    logic signed [SW-1:0]    xs;
    logic signed [SW:0]      ema_diff, lp_diff;
    logic signed [SW+18:0]   ema_prod;
    logic signed [SW+25:0]   lp_prod;
    logic signed [SW+18:0]   ema_rnd;
    logic signed [SW+25:0]   lp_rnd;
    logic [DEN_W:0]          rem_sh;
    logic signed [SW-1:0]    st_sel;
    logic signed [SW:0]      st_rnd;
    logic signed [S:0]       med_sum;

    assign xs = {x_reg, {FRAC_EXTRA{1'b0}}};
    assign dt_fix = (step_micros == '0 || step_micros > MAX_STEP) ? DEFAULT_STEP : step_micros;
    assign fc_fix = (cutoff_millihertz == '0) ? MIN_CUTOFF : cutoff_millihertz;
    assign alpha  = (ema_weight > ALPHA_ONE) ? ALPHA_ONE : ema_weight;

    always_comb begin
        wlen_calc = (median_window == '0) ? CNT_W'(1) : median_window;
        if (wlen_calc > D_CNT) begin
            wlen_calc = D_CNT;
        end
        if (wlen_calc > held_reg) begin
            wlen_calc = held_reg;
        end
    end

    assign ema_diff = {xs[SW-1], xs} - {avg_reg[SW-1], avg_reg};
    assign lp_diff  = {xs[SW-1], xs} - {lp_reg[SW-1], lp_reg};
    assign ema_prod = $signed({1'b0, alpha}) * ema_diff;
    assign lp_prod  = $signed({1'b0, q_reg}) * lp_diff;
    assign ema_rnd  = (ema_prod + (SW+19)'(32768)) >>> 16;
    assign lp_rnd   = (lp_prod + (SW+26)'(1 << (GAIN_BITS - 1))) >>> GAIN_BITS;
    assign rem_sh   = {rem_reg, 1'b0};

    assign sts.mode_med = filter_mode[1];
    assign sts.mode_lp  = (filter_mode == MODE_LP);
    assign sts.half     = (wlen_reg - CNT_W'(1)) >> 1;

    always_comb begin
        st_sel = (filter_mode == MODE_EMA) ? avg_reg : lp_reg;
        st_rnd = ($signed({st_sel[SW-1], st_sel}) + (SW+1)'(1 << (FRAC_EXTRA - 1)))
                 >>> FRAC_EXTRA;
        med_sum = ({srt_reg[0][S-1], srt_reg[0]} + {srt_reg[D > 1 ? 1 : 0][S-1],
                   srt_reg[D > 1 ? 1 : 0]} + (S+1)'(1)) >>> 1;
        if (filter_mode[1]) begin
            filtered_out = wlen_reg[0] ? srt_reg[0] : med_sum[S-1:0];
        end else if (st_rnd > Y_HI) begin
            filtered_out = Y_HI[S-1:0];
        end else if (st_rnd < Y_LO) begin
            filtered_out = Y_LO[S-1:0];
        end else begin
            filtered_out = st_rnd[S-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg  <= sample_in;
            dt_reg <= dt_fix;
        end
        if (cmd.mul0) begin
            p_reg <= P_W'(dt_reg * fc_fix);
        end
        if (cmd.mul_lo) begin
            w_reg <= W_W'(p_reg[19:0] * TWO_PI_Q16);
        end else if (cmd.mul_hi) begin
            w_reg <= w_reg + (W_W'(p_reg[P_W-1:20] * TWO_PI_Q16) << 20);
        end
        if (cmd.div_init) begin
            den_reg <= UNIT_SCALED + DEN_W'(w_reg);
            rem_reg <= DEN_W'(w_reg);
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= DEN_W'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[GAIN_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DEN_W-1:0];
                q_reg   <= {q_reg[GAIN_BITS-2:0], 1'b0};
            end
        end
        if (cmd.sort_load) begin
            wlen_reg <= wlen_calc;
            for (int i = 0; i < D; i++) begin
                srt_reg[i] <= win_reg[i];
                inv_reg[i] <= (CNT_W'(i) >= wlen_calc);
            end
        end else if (cmd.sort_step) begin
            for (int i = 0; i + 1 < D; i++) begin
                if ((i % 2) == int'(cmd.phase)) begin
                    if ((inv_reg[i] && !inv_reg[i+1]) || (!inv_reg[i] && !inv_reg[i+1]
                            && srt_reg[i] > srt_reg[i+1])) begin
                        srt_reg[i]   <= srt_reg[i+1];
                        srt_reg[i+1] <= srt_reg[i];
                        inv_reg[i]   <= inv_reg[i+1];
                        inv_reg[i+1] <= inv_reg[i];
                    end
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i + 1 < D; i++) begin
                srt_reg[i] <= srt_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            seeded_reg <= 1'b0;
            avg_reg    <= '0;
            lp_reg     <= '0;
            held_reg   <= '0;
            for (int i = 0; i < D; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            if (!seeded_reg) begin
                seeded_reg <= 1'b1;
                avg_reg    <= {sample_in, {FRAC_EXTRA{1'b0}}};
                lp_reg     <= {sample_in, {FRAC_EXTRA{1'b0}}};
            end
            if (filter_mode[1]) begin
                win_reg[0] <= sample_in;
                for (int i = 1; i < D; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
                if (held_reg < D_CNT) begin
                    held_reg <= held_reg + 1'b1;
                end
            end
        end else if (cmd.update) begin
            if (filter_mode == MODE_EMA) begin
                avg_reg <= avg_reg + ema_rnd[SW-1:0];
            end else begin
                lp_reg <= lp_reg + lp_rnd[SW-1:0];
            end
        end
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= D_CNT)
        else $error("held count above window depth");
    a_wlen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sort_load && !cfg_clear) |=> (wlen_reg != '0 && wlen_reg <= held_reg))
        else $error("median window length out of range");

endmodule : sef_datapath
`default_nettype wire
